FILE: rtl/core/lfq_pkg.sv
package lfq_pkg;

    // width of the result payload port
    localparam int unsigned DATA_W = 32;

    // operation codes carried by func
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UPDATE,
        ST_LINK,
        ST_DONE
    } lfq_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic update;
        logic link;
        logic load_result;
    } lfq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_pop;
        logic err;
        logic out_free;
    } lfq_status_t;

endpackage

FILE: rtl/core/lfq_ctrl.sv
module lfq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lfq_pkg::lfq_status_t status,
    output lfq_pkg::lfq_cmd_t    cmd
);
    import lfq_pkg::*;

    lfq_state_t state_reg;
    lfq_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.err ? ST_DONE : ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.is_pop ? ST_DONE : ST_LINK;
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/core/lfq_datapath.sv
module lfq_datapath #(
    parameter int unsigned NODE_COUNT    = 16,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_func,
    input  logic [lfq_pkg::DATA_W-1:0]    s_data_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lfq_pkg::DATA_W-1:0]    m_data_out,
    output logic                          m_error,
    output logic                          m_empty_res,
    output logic                          m_full_res,
    input  lfq_pkg::lfq_cmd_t             cmd,
    output lfq_pkg::lfq_status_t          status
);
    import lfq_pkg::*;

    localparam int unsigned PTR_W = $clog2(NODE_COUNT + 1);
    localparam int unsigned IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    // node stores
    logic [PTR_W-1:0]         link_mem [NODE_COUNT];
    logic [PAYLOAD_WIDTH-1:0] payload_mem [NODE_COUNT];

    // item and pointer registers
    logic              func_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PTR_W-1:0]  free_head_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  node_reg;
    logic [PTR_W-1:0]  wmark_reg;
    logic              err_reg;
    logic [DATA_W-1:0] pop_data_reg;

    // read side of the stores
    logic [PTR_W-1:0]         link_rd_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_rd_reg;
    logic                     ovr_reg;
    logic [PTR_W-1:0]         seq_reg;

    // result register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_error_reg;
    logic              m_empty_reg;
    logic              m_full_reg;

    logic             is_pop;
    logic             op_err;
    logic [PTR_W-1:0] ex_addr;
    logic [PTR_W-1:0] link_val;
    logic [PTR_W-1:0] link_next;
    logic             tail_valid;
    logic             link_we;
    logic [PTR_W-1:0] link_waddr;
    logic [PTR_W-1:0] link_wdata;

    assign is_pop     = (func_reg == FUNC_POP);
    assign op_err     = is_pop ? (head_reg >= NIL) : (free_head_reg >= NIL);
    assign ex_addr    = is_pop ? head_reg : free_head_reg;
    assign tail_valid = (tail_reg < NIL);

    // entries at or above the watermark were never written and are read as pointing to i+1
    assign link_val  = ovr_reg ? seq_reg : link_rd_reg;
    assign link_next = (link_val >= NIL) ? NIL : link_val;

    assign status.is_pop   = is_pop;
    assign status.err      = op_err;
    assign status.out_free = !m_valid_reg || m_ready;

    // link store write port
    always_comb begin
        link_we    = 1'b0;
        link_waddr = node_reg;
        link_wdata = NIL;
        if (cmd.update) begin
            link_we    = 1'b1;
            link_waddr = node_reg;
            link_wdata = is_pop ? free_head_reg : NIL;
        end else if (cmd.link && tail_valid) begin
            link_we    = 1'b1;
            link_waddr = tail_reg;
            link_wdata = node_reg;
        end
    end

    // link store
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr[IDX_W-1:0]] <= link_wdata;
        end
        if (cmd.exec) begin
            link_rd_reg <= link_mem[ex_addr[IDX_W-1:0]];
        end
    end

    // payload store
    always_ff @(posedge aclk) begin
        if (cmd.exec && !op_err && !is_pop) begin
            payload_mem[ex_addr[IDX_W-1:0]] <= PAYLOAD_WIDTH'(data_reg);
        end
        if (cmd.exec) begin
            pay_rd_reg <= payload_mem[ex_addr[IDX_W-1:0]];
        end
    end

    // item capture and read-side bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg <= s_func;
            data_reg <= s_data_in;
        end
        if (cmd.exec) begin
            node_reg     <= ex_addr;
            ovr_reg      <= (ex_addr >= wmark_reg);
            seq_reg      <= ex_addr + PTR_W'(1);
            err_reg      <= op_err;
            pop_data_reg <= '0;
        end
        if (cmd.update && is_pop) begin
            pop_data_reg <= DATA_W'(pay_rd_reg);
        end
    end

    // list pointers and watermark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            wmark_reg     <= '0;
        end else begin
            if (cmd.exec && !op_err && !is_pop && (free_head_reg == wmark_reg)) begin
                wmark_reg <= wmark_reg + PTR_W'(1);
            end
            if (cmd.update) begin
                if (is_pop) begin
                    free_head_reg <= node_reg;
                    head_reg      <= link_next;
                    if (link_next >= NIL) begin
                        tail_reg <= NIL;
                    end
                end else begin
                    free_head_reg <= link_next;
                end
            end
            if (cmd.link) begin
                tail_reg <= node_reg;
                if (head_reg >= NIL) begin
                    head_reg <= node_reg;
                end
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_data_reg  <= pop_data_reg;
            m_error_reg <= err_reg;
            m_empty_reg <= (head_reg >= NIL);
            m_full_reg  <= (free_head_reg >= NIL);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data_out  = m_data_reg;
    assign m_error     = m_error_reg;
    assign m_empty_res = m_empty_reg;
    assign m_full_res  = m_full_reg;

    // head and tail are null together
    a_head_tail_nil: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg >= NIL) == (tail_reg >= NIL))
        else $error("queue head and tail disagree on empty");

    // watermark never passes the node count
    a_wmark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wmark_reg <= NIL)
        else $error("watermark out of range");

    // a node is never both free head and queue head
    a_free_vs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg < NIL && head_reg < NIL) |-> (free_head_reg != head_reg))
        else $error("node on both lists");

    // a result never reports empty and full at once
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_empty_reg && m_full_reg))
        else $error("result is both empty and full");

endmodule

FILE: rtl/core/linked_fifo_with_free_list.sv
// push: EXEC, UPDATE, LINK, DONE; pop: EXEC, UPDATE, DONE; rejected: EXEC, DONE,
// from input accept to result valid, DONE waiting for a free result register
// throughput: one item at a time; set by the
// single write port of the link store and its registered read
// reset: synchronous active-low aresetn empties the queue and puts every node
// on the free list at once, with no clearing pass; payload words are not cleared
module linked_fifo_with_free_list #(
    parameter int unsigned NODE_COUNT    = 16,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [lfq_pkg::DATA_W-1:0] s_data_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lfq_pkg::DATA_W-1:0] m_data_out,
    output logic                       m_error,
    output logic                       m_empty_res,
    output logic                       m_full_res
);
    import lfq_pkg::*;

    lfq_cmd_t    cmd;
    lfq_status_t status;

    // sequencing of one item
    lfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // node stores, list pointers and result register
    lfq_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_func      (s_func),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_error     (m_error),
        .m_empty_res (m_empty_res),
        .m_full_res  (m_full_res),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: dv/lfq_result_checker.sv
module lfq_result_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_func,
    input  logic [lfq_pkg::DATA_W-1:0] s_data_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [lfq_pkg::DATA_W-1:0] m_data_out,
    input  logic                       m_error,
    input  logic                       m_empty_res,
    input  logic                       m_full_res,
    output int                         fail_count,
    output int                         pending_count,
    output int                         checked_count,
    output int                         rejected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lfq_pkg::*;

    localparam int         NODES    = 16;
    localparam logic [4:0] NIL_NODE = 5'(NODES);

    // one expected result item
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              error;
        logic              empty;
        logic              full;
    } queue_result_t;

    // shadow copy of the node store and its list pointers
    logic [4:0]        next_node [NODES];
    logic [DATA_W-1:0] node_data [NODES];
    logic [4:0]        free_top;
    logic [4:0]        fifo_head;
    logic [4:0]        fifo_tail;

    queue_result_t pending_results [$];

    function automatic logic is_node(logic [4:0] ptr);
        return ptr < NODES;
    endfunction

    // apply one push or pop to the shadow lists and return its result
    function automatic queue_result_t compute_queue_result(logic op, logic [DATA_W-1:0] value);
        queue_result_t res;
        logic [4:0]    node;
        res = '0;
        if (op == FUNC_PUSH) begin
            if (!is_node(free_top)) begin
                res.error = 1'b1;
            end else begin
                node = free_top;
                free_top = is_node(next_node[node]) ? next_node[node] : NIL_NODE;
                node_data[node] = value;
                next_node[node] = NIL_NODE;
                if (is_node(fifo_tail)) begin
                    next_node[fifo_tail] = node;
                end
                fifo_tail = node;
                if (!is_node(fifo_head)) begin
                    fifo_head = node;
                end
            end
        end else begin
            if (!is_node(fifo_head)) begin
                res.error = 1'b1;
            end else begin
                node = fifo_head;
                res.data = node_data[node];
                fifo_head = next_node[node];
                if (!is_node(fifo_head)) begin
                    fifo_head = NIL_NODE;
                    fifo_tail = NIL_NODE;
                end
                next_node[node] = free_top;
                free_top = node;
            end
        end
        res.empty = !is_node(fifo_head);
        res.full  = !is_node(free_top);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        fail_count++;
    endtask

    // compare result items first, then predict from accepted input items
    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                next_node[i] = 5'(i + 1);
            end
            next_node[NODES-1] = NIL_NODE;
            free_top  = '0;
            fifo_head = NIL_NODE;
            fifo_tail = NIL_NODE;
            pending_results.delete();
            fail_count     = 0;
            checked_count  = 0;
            rejected_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result item with nothing pending, data_out %h",
                                              m_data_out));
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (m_data_out !== want.data) begin
                        report_mismatch($sformatf("data_out got %h want %h",
                                                  m_data_out, want.data));
                    end
                    if (m_error !== want.error) begin
                        report_mismatch($sformatf("error got %b want %b", m_error, want.error));
                    end
                    if (m_empty_res !== want.empty) begin
                        report_mismatch($sformatf("empty_res got %b want %b",
                                                  m_empty_res, want.empty));
                    end
                    if (m_full_res !== want.full) begin
                        report_mismatch($sformatf("full_res got %b want %b",
                                                  m_full_res, want.full));
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = compute_queue_result(s_func, s_data_in);
                if (want.error) begin
                    rejected_count++;
                end
                pending_results.push_back(want);
            end
        end
        pending_count = pending_results.size();
    end

endmodule

FILE: dv/linked_fifo_with_free_list_tb.sv
module linked_fifo_with_free_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfq_pkg::*;

    // idle patterns of the two channels
    localparam int PH_STEADY      = 0;
    localparam int PH_SEND_GAPS   = 1;
    localparam int PH_RECV_STALLS = 2;
    localparam int PH_BOTH        = 3;

    localparam int RANDOM_ITEMS = 550;
    localparam int PHASE_LEN    = 70;
    localparam int SEG_LEN      = 30;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_func    = FUNC_PUSH;
    logic [DATA_W-1:0] s_data_in = '0;
    logic              m_ready   = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [DATA_W-1:0] m_data_out;
    logic              m_error;
    logic              m_empty_res;
    logic              m_full_res;

    int fail_count;
    int pending_count;
    int checked_count;
    int rejected_count;
    int idle_phase = PH_STEADY;
    int push_sent  = 0;
    int pop_sent   = 0;

    always #2 aclk = ~aclk;

    linked_fifo_with_free_list #(
        .NODE_COUNT    (16),
        .PAYLOAD_WIDTH (32)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_error     (m_error),
        .m_empty_res (m_empty_res),
        .m_full_res  (m_full_res)
    );

    lfq_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_data_in      (s_data_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data_out     (m_data_out),
        .m_error        (m_error),
        .m_empty_res    (m_empty_res),
        .m_full_res     (m_full_res),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .rejected_count (rejected_count)
    );

    // result side back-pressure
    always @(negedge aclk) begin
        case (idle_phase)
            PH_RECV_STALLS: m_ready <= ($urandom_range(99) >= 72);
            PH_BOTH:        m_ready <= ($urandom_range(99) >= 12);
            default:        m_ready <= 1'b1;
        endcase
    end

    // present one item, starting and ending at a falling edge
    task automatic send_item(input logic op, input logic [DATA_W-1:0] value);
        int idle_pct;
        idle_pct = (idle_phase == PH_SEND_GAPS) ? 72 : (idle_phase == PH_BOTH) ? 12 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= op;
        s_data_in <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (op == FUNC_PUSH) begin
            push_sent++;
        end else begin
            pop_sent++;
        end
    endtask

    initial begin
        int   push_pct;
        logic op;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: payload extremes, pops on an empty queue, ignored pop data
        send_item(FUNC_POP,  32'hFFFF_FFFF);
        send_item(FUNC_PUSH, 32'h0000_0000);
        send_item(FUNC_PUSH, 32'hFFFF_FFFF);
        send_item(FUNC_POP,  32'h0000_0000);
        send_item(FUNC_PUSH, 32'h8000_0001);
        send_item(FUNC_PUSH, 32'h7FFF_FFFE);
        send_item(FUNC_POP,  32'h1234_5678);
        send_item(FUNC_POP,  32'hFFFF_FFFF);
        send_item(FUNC_POP,  32'h0000_0000);
        send_item(FUNC_POP,  32'hFFFF_FFFF);
        send_item(FUNC_PUSH, 32'hA5A5_A5A5);
        send_item(FUNC_POP,  32'h5A5A_5A5A);
        send_item(FUNC_POP,  32'h0000_0000);

        // random: alternate fill and drain biases so full and empty recur
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_LEN == 0) begin
                // let the block drain before switching idle pattern
                s_valid <= 1'b0;
                do @(negedge aclk); while (pending_count != 0);
                idle_phase = (i / PHASE_LEN) % 4;
            end
            case ((i / SEG_LEN) % 5)
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 50;
                3:       push_pct = 90;
                default: push_pct = 10;
            endcase
            op = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
            send_item(op, $urandom);
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (20) @(negedge aclk);

        $display("covered %0d pushes and %0d pops under four idle patterns", push_sent, pop_sent);
        $display("%0d result items checked, %0d of them rejected on full or empty",
                 checked_count, rejected_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
